@@ sv/otgs_pkg.sv @@
`timescale 1ns / 1ps

package otgs_pkg;

    // Grid size in cells.
    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;

    // Field widths of the channels.
    localparam int ACT_W   = 2;
    localparam int COORD_W = 8;
    localparam int MASK_W  = 9;
    localparam int CFG_IDX_W = 1;

    // Row store: one memory entry per grid row, one bit per column.
    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int ROW_XW = (ROW_AW > COORD_W) ? ROW_AW : COORD_W;
    localparam int COL_XW = (COL_AW > COORD_W) ? COL_AW : COORD_W;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 1'b1;

    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;

endpackage

@@ sv/otgs_if.sv @@
`timescale 1ns / 1ps

interface otgs_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [otgs_pkg::ACT_W-1:0]     action;
    logic [otgs_pkg::COORD_W-1:0]   col;
    logic [otgs_pkg::COORD_W-1:0]   row;
    logic                           cell_in;

    modport source (output valid, output action, output col, output row, output cell_in,
                    input ready);
    modport sink   (input valid, input action, input col, input row, input cell_in,
                    output ready);
endinterface

interface otgs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [otgs_pkg::ACT_W-1:0]     done_action;
    logic                           cell_out;

    modport source (output valid, output done_action, output cell_out, input ready);
    modport sink   (input valid, input done_action, input cell_out, output ready);
endinterface

@@ sv/otgs_ram.sv @@
`timescale 1ns / 1ps

module otgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/outer_totalistic_grid_step_top.sv @@
`timescale 1ns / 1ps

// Channel   Role    Handshake          Word
// cmd       sink    valid / ready      action, col, row, cell_in
// rsp       source  valid / ready      done_action, cell_out
// cfg       write   cfg_we             cfg_index, cfg_wdata (survive, birth masks)
//
// One item is in work at a time. A read or write passes through the access and finish states:
// a row read from the row store, then the modify and write back, then its result word is
// loaded into the result register.
// A generation is one raster pass of row reads, each new row computed across its full width
// from three buffered rows and written back in place.
// After reset a clearing pass writes every row dead, with cmd not ready.
// The result register lets the next word be accepted while a result waits; an item only
// stalls at its end if the previous result is still untaken.

module outer_totalistic_grid_step_top (
    input  logic                              clk,
    input  logic                              rst_n,
    otgs_cmd_if.sink                          cmd,
    otgs_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [otgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [otgs_pkg::MASK_W-1:0]       cfg_wdata
);

    localparam int W      = otgs_pkg::GRID_WIDTH;
    localparam int H      = otgs_pkg::GRID_HEIGHT;
    localparam int ROW_AW = otgs_pkg::ROW_AW;
    localparam int COL_AW = otgs_pkg::COL_AW;
    localparam int CNT_W  = $clog2(H + 2);

    localparam logic [CNT_W-1:0] CNT_H    = CNT_W'(H);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(H + 1);
    localparam logic [CNT_W-1:0] CNT_CLR  = CNT_W'(H - 1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_GEN,
        ST_FIN
    } state_t;

    // New row from the old rows above, at and below it; cells past either edge are dead.
    function automatic logic [W-1:0] next_row(
        input logic [W-1:0]                 above,
        input logic [W-1:0]                 mid,
        input logic [W-1:0]                 below,
        input logic [otgs_pkg::MASK_W-1:0]  survive,
        input logic [otgs_pkg::MASK_W-1:0]  birth
    );
        logic [W+1:0] ap;
        logic [W+1:0] mp;
        logic [W+1:0] bp;
        logic [3:0]   n;
        logic [W-1:0] res;
        ap = {1'b0, above, 1'b0};
        mp = {1'b0, mid, 1'b0};
        bp = {1'b0, below, 1'b0};
        res = '0;
        for (int i = 0; i < W; i++)
        begin
            n = 4'(ap[i]) + 4'(ap[i+1]) + 4'(ap[i+2])
              + 4'(mp[i]) + 4'(mp[i+2])
              + 4'(bp[i]) + 4'(bp[i+1]) + 4'(bp[i+2]);
            res[i] = mp[i+1] ? survive[n] : birth[n];
        end
        return res;
    endfunction

    state_t                            state_reg, state_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [otgs_pkg::ACT_W-1:0]        act_reg, act_next;
    logic [ROW_AW-1:0]                 row_reg, row_next;
    logic [COL_AW-1:0]                 col_reg, col_next;
    logic                              cell_reg, cell_next;
    logic                              inside_reg, inside_next;
    logic                              res_cell_reg, res_cell_next;
    logic [W-1:0]                      above_reg, above_next;
    logic [W-1:0]                      mid_reg, mid_next;
    logic                              out_valid_reg, out_valid_next;
    logic [otgs_pkg::ACT_W-1:0]        out_action_reg, out_action_next;
    logic                              out_cell_reg, out_cell_next;
    logic [otgs_pkg::MASK_W-1:0]       survive_reg, survive_next;
    logic [otgs_pkg::MASK_W-1:0]       birth_reg, birth_next;

    logic                              ram_we;
    logic [ROW_AW-1:0]                 ram_wr_addr;
    logic [W-1:0]                      ram_wr_data;
    logic                              ram_rd_en;
    logic [ROW_AW-1:0]                 ram_rd_addr;
    logic [W-1:0]                      ram_rd_data;

    logic                              accept;
    logic                              out_free;
    logic [otgs_pkg::ROW_XW-1:0]       in_row_x;
    logic [otgs_pkg::COL_XW-1:0]       in_col_x;
    logic                              in_inside;
    logic [W-1:0]                      row_mod;
    logic [W-1:0]                      below;

    otgs_ram #(
        .WIDTH (W),
        .DEPTH (H)
    ) u_row_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign accept          = cmd.valid && cmd.ready;
    assign out_free        = !out_valid_reg || rsp.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.done_action = out_action_reg;
    assign rsp.cell_out    = out_cell_reg;

    assign in_row_x  = otgs_pkg::ROW_XW'(cmd.row);
    assign in_col_x  = otgs_pkg::COL_XW'(cmd.col);
    assign in_inside = (32'(cmd.row) < H) && (32'(cmd.col) < W);

    always_comb
    begin
        row_mod          = ram_rd_data;
        row_mod[col_reg] = cell_reg;
    end

    // The row below is real data only while rows are still arriving from the store.
    assign below = ((cnt_reg != '0) && (cnt_reg <= CNT_H)) ? ram_rd_data : '0;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cell_next       = cell_reg;
        inside_next     = inside_reg;
        res_cell_next   = res_cell_reg;
        above_next      = above_reg;
        mid_next        = mid_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_cell_next   = out_cell_reg;
        survive_next    = survive_reg;
        birth_next      = birth_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                otgs_pkg::CFG_SURVIVE: survive_next = cfg_wdata;
                otgs_pkg::CFG_BIRTH:   birth_next   = cfg_wdata;
                default:               ;
            endcase
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = cnt_reg[ROW_AW-1:0];
                if (cnt_reg == CNT_CLR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next      = cmd.action;
                    row_next      = in_row_x[ROW_AW-1:0];
                    col_next      = in_col_x[COL_AW-1:0];
                    cell_next     = cmd.cell_in;
                    inside_next   = in_inside;
                    res_cell_next = 1'b0;
                    case (cmd.action)
                        otgs_pkg::ACT_WRITE,
                        otgs_pkg::ACT_READ:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = in_row_x[ROW_AW-1:0];
                            state_next  = ST_ACCESS;
                        end
                        otgs_pkg::ACT_STEP:
                        begin
                            cnt_next   = '0;
                            above_next = '0;
                            mid_next   = '0;
                            state_next = ST_GEN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (act_reg == otgs_pkg::ACT_WRITE)
                begin
                    ram_we      = inside_reg;
                    ram_wr_addr = row_reg;
                    ram_wr_data = row_mod;
                end
                else
                begin
                    res_cell_next = inside_reg && ram_rd_data[col_reg];
                end
                state_next = ST_FIN;
            end
            ST_GEN:
            begin
                // Row cnt is read now; row cnt-2 is rewritten once its row below is in hand.
                if (cnt_reg < CNT_H)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cnt_reg[ROW_AW-1:0];
                end
                if (cnt_reg >= CNT_TWO)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = ROW_AW'(cnt_reg - CNT_TWO);
                    ram_wr_data = next_row(above_reg, mid_reg, below, survive_reg, birth_reg);
                end
                above_next = mid_reg;
                mid_next   = below;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = act_reg;
                    out_cell_next   = res_cell_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            act_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            cell_reg       <= 1'b0;
            inside_reg     <= 1'b0;
            res_cell_reg   <= 1'b0;
            above_reg      <= '0;
            mid_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_action_reg <= '0;
            out_cell_reg   <= 1'b0;
            survive_reg    <= otgs_pkg::SURVIVE_RESET;
            birth_reg      <= otgs_pkg::BIRTH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            act_reg        <= act_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cell_reg       <= cell_next;
            inside_reg     <= inside_next;
            res_cell_reg   <= res_cell_next;
            above_reg      <= above_next;
            mid_reg        <= mid_next;
            out_valid_reg  <= out_valid_next;
            out_action_reg <= out_action_next;
            out_cell_reg   <= out_cell_next;
            survive_reg    <= survive_next;
            birth_reg      <= birth_next;
        end
    end

endmodule
